// File: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 2;
  localparam int unsigned MAX_BUTTONS     = 16;

  localparam int unsigned PIN_W   = 2;
  localparam int unsigned IDX_W   = 1;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CNT_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 1'd1;

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_COUNT = 2'd1,
    PHASE_LONG  = 2'd2
  } bpc_phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } bpc_event_e;

endpackage

// File: rtl/core/bpc_in_if.sv
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: tick or read beat with valid/ready.
// ----------------------------------------------------------------------------
interface bpc_in_if
  import bpc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIN_W-1:0] pin_levels;
  logic [IDX_W-1:0] button_index;

  modport source (output valid, operation, pin_levels, button_index, input ready);
  modport sink   (input valid, operation, pin_levels, button_index, output ready);
endinterface

// File: rtl/core/bpc_out_if.sv
// ----------------------------------------------------------------------------
// bpc_out_if
// Output channel: event code beat with valid/ready.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

// File: rtl/core/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Per-button short/long press classification with latched read-and-clear
// events.
// ----------------------------------------------------------------------------
//  port      | dir | beat contents
//  ----------+-----+------------------------------------------------
//  in_i      | in  | operation, pin_levels, button_index
//  out_o     | out | event_code (one beat per read, none per tick)
//  cfg_*_i   | in  | register index, 16-bit data, write enable
//
//  One beat per cycle while in_i.ready is high; per-button state updates at the accepting edge.
//  A read result sits in the output register the cycle after its beat.
//  in_i.ready drops only while the output register is full and stalled.
//  Reset clears all button state, pending events and the output valid flag; the output code is not reset.
// ----------------------------------------------------------------------------
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned NumButtons = NUM_BUTTONS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bpc_in_if.sink               in_i,
  bpc_out_if.source            out_o
);

  logic [CNT_W-1:0] debounce_q, long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      long_q     <= LONG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_LONG:     long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic       out_valid_q;
  logic [1:0] out_code_q;
  logic       accept, do_tick, do_read;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign do_tick    = accept && (in_i.operation == OP_TICK);
  assign do_read    = accept && (in_i.operation == OP_READ);

  bpc_phase_e       phase_q [NumButtons];
  bpc_phase_e       phase_d [NumButtons];
  logic [CNT_W-1:0] count_q [NumButtons];
  logic [CNT_W-1:0] count_d [NumButtons];
  logic [1:0]       pend_q  [NumButtons];
  logic [1:0]       pend_d  [NumButtons];
  logic [NumButtons-1:0] pressed, sel;

  for (genvar b = 0; b < NumButtons; b++) begin : g_btn
    if (b < PIN_W) begin : g_pin
      assign pressed[b] = in_i.pin_levels[b];
    end else begin : g_nopin
      assign pressed[b] = 1'b0;
    end
    if (b < (1 << IDX_W)) begin : g_sel
      assign sel[b] = do_read && (in_i.button_index == IDX_W'(b));
    end else begin : g_nosel
      assign sel[b] = 1'b0;
    end

    always_comb begin
      logic [CNT_W-1:0] inc;
      phase_d[b] = phase_q[b];
      count_d[b] = count_q[b];
      pend_d[b]  = pend_q[b];
      inc = (count_q[b] != CNT_MAX) ? count_q[b] + 1'b1 : count_q[b];
      if (do_tick) begin
        if (pressed[b]) begin
          if (phase_q[b] == PHASE_IDLE || phase_q[b] == PHASE_COUNT) begin
            phase_d[b] = PHASE_COUNT;
            count_d[b] = inc;
            if (inc >= long_q) begin
              pend_d[b]  = EV_LONG;
              phase_d[b] = PHASE_LONG;
            end
          end
        end else begin
          if (phase_q[b] == PHASE_COUNT && count_q[b] >= debounce_q) begin
            pend_d[b] = EV_SHORT;
          end
          phase_d[b] = PHASE_IDLE;
          count_d[b] = '0;
        end
      end else if (sel[b]) begin
        pend_d[b] = EV_NONE;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q[b] <= PHASE_IDLE;
        count_q[b] <= '0;
        pend_q[b]  <= EV_NONE;
      end else begin
        phase_q[b] <= phase_d[b];
        count_q[b] <= count_d[b];
        pend_q[b]  <= pend_d[b];
      end
    end
  end

  logic [1:0] read_code;

  always_comb begin
    read_code = EV_NONE;
    for (int b = 0; b < NumButtons; b++) begin
      if (sel[b]) begin
        read_code = read_code | pend_q[b];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= do_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_read) begin
      out_code_q <= read_code;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_code = out_code_q;

endmodule

// File: tb/press_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// press_event_checker
// Watches the tick/read and event channels of the button press classifier.
// It keeps its own copy of the per-button hold phase, hold count, latched
// event and thresholds. It queues the event that each accepted read should
// return and compares every output beat with the oldest queued event.
// ----------------------------------------------------------------------------
module press_event_checker
  import bpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bpc_in_if                    in_mon,
  bpc_out_if                   out_mon,
  output int                   fail_cnt_o,
  output int                   pending_o
);

  bpc_phase_e       phase_q   [NUM_BUTTONS_DEF];
  logic [CNT_W-1:0] hold_q    [NUM_BUTTONS_DEF];
  bpc_event_e       latched_q [NUM_BUTTONS_DEF];
  logic [CFG_W-1:0] debounce_q;
  logic [CFG_W-1:0] long_q;
  bpc_event_e       read_events_q [$];

  task automatic advance_button(input int b, input logic pressed);
    if (pressed) begin
      if (phase_q[b] == PHASE_IDLE) phase_q[b] = PHASE_COUNT;
      if (phase_q[b] == PHASE_COUNT) begin
        if (hold_q[b] != CNT_MAX) hold_q[b] = hold_q[b] + 1'b1;
        if (hold_q[b] >= long_q) begin
          latched_q[b] = EV_LONG;
          phase_q[b]   = PHASE_LONG;
        end
      end
    end else begin
      if (phase_q[b] == PHASE_COUNT && hold_q[b] >= debounce_q) latched_q[b] = EV_SHORT;
      phase_q[b] = PHASE_IDLE;
      hold_q[b]  = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bpc_event_e want;
    int b;
    if (!rst_ni) begin
      for (b = 0; b < NUM_BUTTONS_DEF; b++) begin
        phase_q[b]   = PHASE_IDLE;
        hold_q[b]    = '0;
        latched_q[b] = EV_NONE;
      end
      debounce_q = DEBOUNCE_RST;
      long_q     = LONG_RST;
      read_events_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE: debounce_q = cfg_data_i;
          REG_LONG:     long_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_TICK) begin
          for (b = 0; b < NUM_BUTTONS_DEF; b++) advance_button(b, in_mon.pin_levels[b]);
        end else begin
          read_events_q.push_back(latched_q[in_mon.button_index]);
          latched_q[in_mon.button_index] = EV_NONE;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (read_events_q.size() == 0) begin
          $error("event_code beat %0d with no read outstanding", out_mon.event_code);
          fail_cnt_o++;
        end else begin
          want = read_events_q.pop_front();
          if (out_mon.event_code !== want) begin
            $error("event_code mismatch: expected %0d, actual %0d", want, out_mon.event_code);
            fail_cnt_o++;
          end
        end
      end
    end
    pending_o = read_events_q.size();
  end

endmodule

// File: tb/tb_button_press_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_press_classifier
// Drives tick and read beats into the button press classifier: a short
// directed sequence of short, long, overwritten and ignored presses, then
// random press/release sequences with reads and pin noise under several
// threshold settings and idle/stall patterns. A separate checker predicts
// and compares every event beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_press_classifier;
  import bpc_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int SETTLE_CYCLES  = 4;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int fail_cnt;
  int pending_reads;
  int quiet_cycles = 0;
  int src_gap_pct  = 0;
  int snk_stall_pct = 0;
  int holdoff_reqs  = 0;
  int holdoff_seen  = 0;
  int holdoff_left  = 0;
  int press_left [NUM_BUTTONS_DEF];

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  always #6 clk_i = ~clk_i;

  button_press_classifier DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  press_event_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_reads)
  );

  // event sink: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ch.ready <= 1'b0;
    end else if (holdoff_reqs != holdoff_seen) begin
      holdoff_seen <= holdoff_reqs;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic put_beat(input logic op, input logic [PIN_W-1:0] pins,
                          input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.pin_levels   <= pins;
    in_ch.button_index <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_events();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DEBOUNCE;
    cfg_data <= deb;
    @(posedge clk_i);
    cfg_idx  <= REG_LONG;
    cfg_data <= lng;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // mostly clean press/release runs per button, some reads, some pin noise
  task automatic random_beat(input int press_hi);
    logic [PIN_W-1:0] pins;
    int b;
    if ($urandom_range(99) < 30) begin
      put_beat(OP_READ, PIN_W'($urandom), IDX_W'($urandom_range(1)));
    end else begin
      if ($urandom_range(99) < 10) begin
        pins = PIN_W'($urandom_range(3));
      end else begin
        for (b = 0; b < NUM_BUTTONS_DEF; b++) begin
          if (press_left[b] > 0) begin
            pins[b] = 1'b1;
            press_left[b]--;
          end else begin
            pins[b] = 1'b0;
            if ($urandom_range(99) < 35) press_left[b] = $urandom_range(press_hi, 1);
          end
        end
      end
      put_beat(OP_TICK, pins, IDX_W'($urandom));
    end
  endtask

  task automatic run_phase(input int deb, input int lng, input int n_beats,
                           input int gap_pct, input int stall_pct);
    int hi;
    int i;
    drain_events();
    load_thresholds(CFG_W'(deb), CFG_W'(lng));
    hi = (lng < deb + 12) ? lng : deb + 12;
    hi = hi + 3;
    if (hi > 60) hi = 60;
    src_gap_pct    = gap_pct;
    snk_stall_pct <= stall_pct;
    for (i = 0; i < n_beats; i++) random_beat(hi);
  endtask

  // sink holds off while reads keep coming, then sender waits for all events
  task automatic flood_reads();
    int i;
    src_gap_pct   = 0;
    holdoff_reqs <= holdoff_reqs + 1;
    for (i = 0; i < 30; i++) begin
      if (i % 2 == 0) put_beat(OP_READ, PIN_W'($urandom), IDX_W'($urandom_range(1)));
      else put_beat(OP_TICK, PIN_W'($urandom_range(3)), IDX_W'($urandom));
    end
    drain_events();
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_TICK;
    in_ch.pin_levels   = '0;
    in_ch.button_index = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_DEBOUNCE;
    cfg_data           = '0;
    for (int b = 0; b < NUM_BUTTONS_DEF; b++) press_left[b] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: debounce 2, long 4
    load_thresholds(16'd2, 16'd4);
    put_beat(OP_READ, 2'b00, 1'b0);
    put_beat(OP_READ, 2'b11, 1'b1);
    repeat (2) put_beat(OP_TICK, 2'b01, 1'b0);
    put_beat(OP_TICK, 2'b00, 1'b1);
    put_beat(OP_READ, 2'b00, 1'b0);
    put_beat(OP_READ, 2'b00, 1'b0);
    repeat (5) put_beat(OP_TICK, 2'b10, 1'b0);
    put_beat(OP_TICK, 2'b00, 1'b0);
    put_beat(OP_READ, 2'b00, 1'b1);
    put_beat(OP_TICK, 2'b11, 1'b1);
    put_beat(OP_TICK, 2'b00, 1'b0);
    put_beat(OP_READ, 2'b00, 1'b0);
    repeat (2) put_beat(OP_TICK, 2'b01, 1'b0);
    put_beat(OP_TICK, 2'b00, 1'b0);
    repeat (4) put_beat(OP_TICK, 2'b01, 1'b0);
    put_beat(OP_TICK, 2'b00, 1'b0);
    put_beat(OP_READ, 2'b00, 1'b0);

    run_phase(30, 1000, 100, 0, 0);
    run_phase(3, 8, 250, 57, 0);
    flood_reads();
    run_phase(0, 1, 150, 0, 57);
    run_phase(0, 0, 100, 7, 7);
    run_phase(5, 5, 150, 0, 0);
    run_phase(65535, 65535, 100, 57, 0);
    run_phase(10, 20, 250, 0, 57);
    run_phase(1, 3, 200, 7, 7);
    drain_events();

    if (fail_cnt == 0 && pending_reads == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
